// ===== hw/rtl/sparse_coordinate_table_defines.svh =====
// Assertion macros for the checker file of the sparse coordinate table.
`ifndef SPARSE_COORDINATE_TABLE_DEFINES_SVH
`define SPARSE_COORDINATE_TABLE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SCT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition checked in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sct_pkg.sv =====
// Package with the request and result types and constants of the sparse coordinate table.
`timescale 1ns / 1ps
package sct_pkg;
    localparam int MaxEntries = 64;
    localparam int IndexBits  = 16;
    localparam int PtrBits    = $clog2(MaxEntries);
    localparam int CountBits  = $clog2(MaxEntries + 1);
    localparam int ExtBits    = IndexBits + 1;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_PRUNE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] row_index;
        logic [15:0] col_index;
        logic signed [31:0] write_value;
        logic signed [15:0] prune_threshold;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic        hit;
        logic [6:0]  entries_held;
        logic [16:0] rows_in_use;
        logic [16:0] cols_in_use;
        logic [6:0]  removed_count;
        logic        status;
    } rsp_t;

    // Classified operation that the front hands to the back.
    typedef enum logic [2:0] {
        OP_LOOKUP = 3'b001,
        OP_WRITE  = 3'b010,
        OP_PRUNE  = 3'b100
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               is_delete;
        logic               none;
        logic [IndexBits-1:0] row;
        logic [IndexBits-1:0] col;
        logic [31:0]        value;
        logic signed [47:0] limit;
    } cmd_t;
endpackage

// ===== hw/rtl/sct_front.sv =====
// Front end: accepts requests, classifies them and forwards commands into a queue.
`timescale 1ns / 1ps
module sct_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sct_pkg::req_t s_data,
    output logic          q_valid,
    input  logic          q_ready,
    output sct_pkg::cmd_t q_cmd
);
    import sct_pkg::*;

    localparam int Depth = 2;

    cmd_t        fifo_reg [Depth];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    cmd_t        cmd;

    // Classify the request into a command for the back end.
    always_comb begin
        cmd           = '0;
        cmd.row       = s_data.row_index[IndexBits-1:0];
        cmd.col       = s_data.col_index[IndexBits-1:0];
        cmd.value     = s_data.write_value;
        cmd.limit     = {{16{s_data.prune_threshold[15]}}, s_data.prune_threshold, 16'h0};
        cmd.is_delete = (s_data.write_value == 32'sd0);
        unique case (s_data.req_type)
            REQ_READ:  cmd.op = OP_LOOKUP;
            REQ_WRITE: cmd.op = OP_WRITE;
            REQ_PRUNE: cmd.op = OP_PRUNE;
            default: begin
                cmd.op   = OP_LOOKUP;
                cmd.none = 1'b1;
            end
        endcase
    end

    assign s_ready = (fill_reg != 2'(Depth));
    assign q_valid = (fill_reg != 2'd0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    // Queue pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (s_valid && s_ready) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_valid && q_ready) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        fill_next = fill_reg + 2'(s_valid && s_ready) - 2'(q_valid && q_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
    end
endmodule

// ===== hw/rtl/sct_back.sv =====
// Back end: walks the entry memory to search, update, compact and prune.
`timescale 1ns / 1ps
module sct_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  sct_pkg::cmd_t q_cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output sct_pkg::rsp_t m_data
);
    import sct_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SRCH   = 6'b000010,
        ST_SCHK   = 6'b000100,
        ST_SHIFT  = 6'b001000,
        ST_PRUNE  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    localparam int EntryBits = 2 * IndexBits + 32;

    logic [EntryBits-1:0] mem [MaxEntries];
    logic [EntryBits-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [CountBits-1:0] count_reg, count_next;
    logic [ExtBits-1:0]   rext_reg, rext_next;
    logic [ExtBits-1:0]   cext_reg, cext_next;
    logic [CountBits-1:0] idx_reg, idx_next;
    logic [CountBits-1:0] wr_idx_reg, wr_idx_next;
    logic [CountBits-1:0] removed_reg, removed_next;
    logic                 hit_reg, hit_next;
    logic                 full_reg, full_next;
    logic [31:0]          rval_reg, rval_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_reg, out_next;

    logic                 rd_en;
    logic [CountBits-1:0] rd_addr;
    logic                 wr_en;
    logic [CountBits-1:0] wr_addr;
    logic [EntryBits-1:0] wr_data;

    logic [IndexBits-1:0] e_row, e_col;
    logic [31:0]          e_val;

    assign {e_row, e_col, e_val} = rd_data_reg;
    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Sequencer: one read issued per step, data checked the step after.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rext_next      = rext_reg;
        cext_next      = cext_reg;
        idx_next       = idx_reg;
        wr_idx_next    = wr_idx_reg;
        removed_next   = removed_reg;
        hit_next       = hit_reg;
        full_next      = full_reg;
        rval_next      = rval_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = wr_idx_reg;
        wr_data        = {cmd_reg.row, cmd_reg.col, cmd_reg.value};

        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    idx_next     = '0;
                    wr_idx_next  = '0;
                    removed_next = '0;
                    hit_next     = 1'b0;
                    full_next    = 1'b0;
                    rval_next    = '0;
                    if (q_cmd.none) begin
                        state_next = ST_DONE;
                    end else if (q_cmd.op == OP_PRUNE) begin
                        state_next = ST_PRUNE;
                    end else begin
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SRCH: begin
                if (idx_reg < count_reg) begin
                    rd_en      = 1'b1;
                    state_next = ST_SCHK;
                end else begin
                    // Position absent.
                    if (cmd_reg.op == OP_WRITE && !cmd_reg.is_delete) begin
                        if (count_reg < CountBits'(MaxEntries)) begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg;
                            count_next = count_reg + 1'b1;
                        end else begin
                            full_next = 1'b1;
                        end
                    end
                    state_next = ST_DONE;
                end
            end
            ST_SCHK: begin
                if (e_row == cmd_reg.row && e_col == cmd_reg.col) begin
                    hit_next = 1'b1;
                    if (cmd_reg.op == OP_LOOKUP) begin
                        rval_next  = e_val;
                        state_next = ST_DONE;
                    end else if (!cmd_reg.is_delete) begin
                        wr_en      = 1'b1;
                        wr_addr    = idx_reg;
                        state_next = ST_DONE;
                    end else begin
                        removed_next = CountBits'(1);
                        wr_idx_next  = idx_reg;
                        idx_next     = idx_reg + 1'b1;
                        state_next   = ST_SHIFT;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRCH;
                end
            end
            ST_SHIFT: begin
                // Move each later entry down one place, read then write.
                if (hit_reg) begin
                    if (idx_reg < count_reg) begin
                        rd_en    = 1'b1;
                        hit_next = 1'b0;
                    end else begin
                        count_next = count_reg - 1'b1;
                        hit_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                end else begin
                    wr_en       = 1'b1;
                    wr_addr     = wr_idx_reg;
                    wr_data     = rd_data_reg;
                    wr_idx_next = wr_idx_reg + 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    hit_next    = 1'b1;
                end
            end
            ST_PRUNE: begin
                // hit_reg marks a pending read whose data is checked next.
                if (hit_reg) begin
                    if ($signed({{16{e_val[31]}}, e_val}) < cmd_reg.limit) begin
                        removed_next = removed_reg + 1'b1;
                    end else begin
                        wr_en       = 1'b1;
                        wr_addr     = wr_idx_reg;
                        wr_data     = rd_data_reg;
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                    hit_next = 1'b0;
                end else if (idx_reg < count_reg) begin
                    rd_en    = 1'b1;
                    hit_next = 1'b1;
                end else begin
                    count_next = wr_idx_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next         = 1'b1;
                    out_next.read_value    = rval_reg;
                    out_next.hit           = (cmd_reg.op == OP_PRUNE) ? 1'b0 : hit_reg;
                    out_next.entries_held  = 7'(count_reg);
                    out_next.rows_in_use   = 17'(rext_reg);
                    out_next.cols_in_use   = 17'(cext_reg);
                    out_next.removed_count = 7'(removed_reg);
                    out_next.status        = full_reg;
                    if (cmd_reg.none) begin
                        out_next.hit = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Extents grow on every nonzero write as it enters.
        if (state_reg == ST_IDLE && q_valid && !q_cmd.none && q_cmd.op == OP_WRITE
                && !q_cmd.is_delete) begin
            if ({1'b0, q_cmd.row} + 1'b1 > rext_reg) begin
                rext_next = {1'b0, q_cmd.row} + 1'b1;
            end
            if ({1'b0, q_cmd.col} + 1'b1 > cext_reg) begin
                cext_next = {1'b0, q_cmd.col} + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rext_reg      <= '0;
            cext_reg      <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rext_reg      <= rext_next;
            cext_reg      <= cext_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            cmd_reg <= q_cmd;
        end
        idx_reg     <= idx_next;
        wr_idx_reg  <= wr_idx_next;
        removed_reg <= removed_next;
        full_reg    <= full_next;
        rval_reg    <= rval_next;
        out_reg     <= out_next;
    end

    // Entry memory: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr[PtrBits-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr[PtrBits-1:0]];
        end
    end
endmodule

// ===== hw/rtl/sparse_coordinate_table.sv =====
// Top level of the sparse coordinate table: front end, command queue and back end.
//
// Usage: each transfer on the s_ channel is a request (read, write, prune); each
// request gives exactly one result transfer on the m_ channel, in order.
// The front end classifies requests into a two-entry command queue, so it takes
// up to two requests while the back end works on an earlier one.
// A read or update walks the list one entry at a time, since the entry memory has a
// single read port; a delete also moves each later entry down one place after the
// match, and a prune visits every entry held.
// Reset clears the entry count and the extents; the entry memory is not cleared,
// since only entries below the count are ever read.
// When the receiver holds m_ready low the result stays in its output register;
// the back end finishes its next command and then waits, and the queue fills.
`timescale 1ns / 1ps
module sparse_coordinate_table (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sct_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sct_pkg::rsp_t m_data
);
    import sct_pkg::*;

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    sct_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    sct_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

// ===== hw/rtl/sct_checker.sv =====
// Port checker for the sparse coordinate table, bound to the top level.
`timescale 1ns / 1ps
`include "sparse_coordinate_table_defines.svh"
module sct_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input sct_pkg::req_t s_data,
    input logic          m_valid,
    input logic          m_ready,
    input sct_pkg::rsp_t m_data
);
    import sct_pkg::*;

    // A stalled request holds its payload until it is taken.
    `SCT_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data), "request changed while stalled")
    // A stalled result holds its payload.
    `SCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    // The entry count never exceeds the table size.
    `SCT_ASSERT_IMPL(a_count_max, aclk, aresetn, m_valid, m_data.entries_held <= 7'(MaxEntries), "entry count above table size")
    // A refused insert never reports a hit and comes with a full table.
    `SCT_ASSERT_IMPL(a_full_nohit, aclk, aresetn, m_valid && m_data.status, !m_data.hit && m_data.entries_held == 7'(MaxEntries), "full status inconsistent")
    // The row extent never shrinks between results.
    `SCT_ASSERT_IMPL(a_ext_mono, aclk, aresetn, m_valid && m_ready ##1 m_valid, m_data.rows_in_use >= $past(m_data.rows_in_use, 1) || !$past(m_valid && m_ready), "row extent shrank")
endmodule

bind sparse_coordinate_table sct_checker u_sct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/sparse_coordinate_table_tb.sv =====
// Testbench for the sparse coordinate table: random and directed requests against a predictor.
`timescale 1ns / 1ps
module sparse_coordinate_table_tb;
    import sct_pkg::*;

    localparam int CycleLimit = 2000000;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    req_t  s_data;
    logic  m_valid;
    logic  m_ready;
    rsp_t  m_data;

    sparse_coordinate_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Predictor copy of the table.
    logic [15:0] tbl_row [MaxEntries];
    logic [15:0] tbl_col [MaxEntries];
    logic [31:0] tbl_val [MaxEntries];
    int          tbl_count;
    logic [16:0] row_ext;
    logic [16:0] col_ext;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   mismatches;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_cycles;
    int   cycle_count;
    bit   s_taken;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Works out the result of one request and updates the predicted table.
    function automatic rsp_t predict_table_op(req_t rq);
        rsp_t rs;
        int pos;
        int w;
        logic signed [47:0] lim;
        rs = '0;
        pos = -1;
        for (int i = 0; i < tbl_count; i++) begin
            if (pos < 0 && tbl_row[i] == rq.row_index && tbl_col[i] == rq.col_index) begin
                pos = i;
            end
        end
        case (rq.req_type)
            REQ_READ: begin
                if (pos >= 0) begin
                    rs.read_value = tbl_val[pos];
                    rs.hit = 1'b1;
                end
            end
            REQ_WRITE: begin
                if (rq.write_value != 0) begin
                    if ({1'b0, rq.row_index} + 17'd1 > row_ext) row_ext = rq.row_index + 17'd1;
                    if ({1'b0, rq.col_index} + 17'd1 > col_ext) col_ext = rq.col_index + 17'd1;
                    if (pos >= 0) begin
                        tbl_val[pos] = rq.write_value;
                        rs.hit = 1'b1;
                    end else if (tbl_count < MaxEntries) begin
                        tbl_row[tbl_count] = rq.row_index;
                        tbl_col[tbl_count] = rq.col_index;
                        tbl_val[tbl_count] = rq.write_value;
                        tbl_count++;
                    end else begin
                        rs.status = 1'b1;
                    end
                end else if (pos >= 0) begin
                    for (int i = pos; i + 1 < tbl_count; i++) begin
                        tbl_row[i] = tbl_row[i+1];
                        tbl_col[i] = tbl_col[i+1];
                        tbl_val[i] = tbl_val[i+1];
                    end
                    tbl_count--;
                    rs.hit = 1'b1;
                    rs.removed_count = 7'd1;
                end
            end
            REQ_PRUNE: begin
                lim = 48'(rq.prune_threshold) <<< 16;
                w = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (48'(signed'(tbl_val[i])) < lim) begin
                        rs.removed_count++;
                    end else begin
                        tbl_row[w] = tbl_row[i];
                        tbl_col[w] = tbl_col[i];
                        tbl_val[w] = tbl_val[i];
                        w++;
                    end
                end
                tbl_count = w;
            end
            default: ;
        endcase
        rs.entries_held = 7'(tbl_count);
        rs.rows_in_use = row_ext;
        rs.cols_in_use = col_ext;
        return rs;
    endfunction

    // Driver: offers queued requests at the falling edge, keeping valid steady until taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_reqs[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness, with a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Predict on each accepted request; the predictor runs at the rising edge.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_rsps.push_back(predict_table_op(s_data));
            void'(pending_reqs.pop_front());
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        rsp_t exp_rsp;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transfer: %p", m_data);
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (m_data !== exp_rsp) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected %p", exp_rsp);
                        $display("          actual   %p", m_data);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic req_t make_req(logic [1:0] op, logic [15:0] r, logic [15:0] c,
                                      logic [31:0] v, logic [15:0] t);
        req_t rq;
        rq.req_type = op;
        rq.row_index = r;
        rq.col_index = c;
        rq.write_value = v;
        rq.prune_threshold = t;
        return rq;
    endfunction

    // Random request: mostly writes and reads into a small coordinate window so hits happen.
    function automatic req_t random_req();
        req_t rq;
        int sel;
        logic [15:0] r;
        logic [15:0] c;
        logic [31:0] v;
        sel = $urandom_range(99);
        if ($urandom_range(9) == 0) begin
            r = 16'($urandom);
            c = 16'($urandom);
        end else begin
            r = 16'($urandom_range(9));
            c = 16'($urandom_range(9));
        end
        case ($urandom_range(3))
            0: v = 32'($urandom);
            1: v = 32'(int'($urandom_range(8)) - 4) << 16;
            2: v = 32'($urandom_range(65535)) - 32'h8000;
            default: v = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
        if (sel < 45) begin
            rq = make_req(REQ_WRITE, r, c, (sel < 8) ? 32'd0 : v, 16'($urandom));
        end else if (sel < 85) begin
            rq = make_req(REQ_READ, r, c, 32'($urandom), 16'($urandom));
        end else if (sel < 97) begin
            rq = make_req(REQ_PRUNE, r, c, 32'($urandom),
                          $urandom_range(3) == 0 ? 16'($urandom) : 16'(int'($urandom_range(8)) - 4));
        end else begin
            rq = make_req(2'd3, 16'($urandom), 16'($urandom), 32'($urandom), 16'($urandom));
        end
        return rq;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        tbl_count = 0;
        row_ext = '0;
        col_ext = '0;
        s_taken = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, every request type and the special cases.
        pending_reqs.push_back(make_req(REQ_READ, 16'd0, 16'd0, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(REQ_WRITE, 16'd3, 16'd4, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(REQ_WRITE, 16'hffff, 16'hffff, 32'h7fff_ffff, 16'd0));
        pending_reqs.push_back(make_req(REQ_WRITE, 16'd0, 16'd0, 32'h8000_0000, 16'd0));
        pending_reqs.push_back(make_req(REQ_WRITE, 16'd1, 16'd2, 32'h0001_0000, 16'd0));
        pending_reqs.push_back(make_req(REQ_WRITE, 16'd1, 16'd2, 32'hffff_0000, 16'd0));
        pending_reqs.push_back(make_req(REQ_READ, 16'd1, 16'd2, 32'hffff_ffff, 16'hffff));
        pending_reqs.push_back(make_req(REQ_READ, 16'hffff, 16'hffff, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(2'd3, 16'hffff, 16'hffff, 32'hffff_ffff, 16'hffff));
        pending_reqs.push_back(make_req(REQ_WRITE, 16'd0, 16'd0, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(REQ_PRUNE, 16'd0, 16'd0, 32'd0, 16'hffff));
        pending_reqs.push_back(make_req(REQ_PRUNE, 16'd0, 16'd0, 32'd0, 16'h8000));
        pending_reqs.push_back(make_req(REQ_PRUNE, 16'd0, 16'd0, 32'd0, 16'h7fff));
        // Fill the table past its capacity, then delete and read from the middle, and prune.
        for (int i = 0; i < MaxEntries + 2; i++) begin
            pending_reqs.push_back(make_req(REQ_WRITE, 16'(i), 16'(i * 3), 32'(i + 1) << 12, 16'd0));
        end
        pending_reqs.push_back(make_req(REQ_WRITE, 16'd5, 16'd15, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(REQ_READ, 16'd6, 16'd18, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(REQ_PRUNE, 16'd0, 16'd0, 32'd0, 16'd2));
        pending_reqs.push_back(make_req(REQ_PRUNE, 16'd0, 16'd0, 32'd0, 16'h7fff));
        wait_drained();

        // Random phases with different idling mixes; one has a long receiver hold-off.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 20; end
            endcase
            for (int n = 0; n < 180; n++) pending_reqs.push_back(random_req());
            if (ph == 4) hold_off_cycles = 3000;
            wait_drained();
        end

        repeat (300) @(posedge aclk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
